// File: rtl/scla_pkg.sv
`timescale 1ns / 1ps

package scla_pkg;

   // line store geometry
   localparam int LINE_BUFFER_SIZE = 64;
   localparam int STORE_DEPTH      = LINE_BUFFER_SIZE - 1;
   localparam int FILL_W           = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W           = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // field widths
   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int CHAR_W = 7;
   localparam int POS_W  = 6;

   // request modes
   localparam logic [MODE_W-1:0] MODE_BYTE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINK_ERR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONSUME  = 2'd2;

   // special characters
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CHR_FIRST = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_LAST  = 8'h7E;

   // byte classes
   localparam int CLS_W = 2;
   localparam logic [CLS_W-1:0] CLS_END    = 2'd0;
   localparam logic [CLS_W-1:0] CLS_ERASE  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_APPEND = 2'd2;
   localparam logic [CLS_W-1:0] CLS_BAD    = 2'd3;

   // tag that travels with a store read
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic             last;
   } rd_tag_type;

   // sort a received byte into its class
   function automatic logic [CLS_W-1:0] classify(input logic [BYTE_W-1:0] b);
      logic [CLS_W-1:0] cls;
      cls = CLS_BAD;
      if (b inside {CHR_CR, CHR_LF}) begin
         cls = CLS_END;
      end else if (b inside {CHR_BS, CHR_DEL}) begin
         cls = CLS_ERASE;
      end else if (b inside {CHR_TAB, [CHR_FIRST:CHR_LAST]}) begin
         cls = CLS_APPEND;
      end
      return cls;
   endfunction

endpackage

// File: rtl/scla_line_ram.sv
`timescale 1ns / 1ps

module scla_line_ram #(
   parameter int DEPTH  = 63,
   parameter int WIDTH  = 7,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/scla_ctrl.sv
`timescale 1ns / 1ps

module scla_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [scla_pkg::MODE_W-1:0]          req_mode,
   input  logic [scla_pkg::BYTE_W-1:0]          req_byte_value,
   input  logic                                 out_free,
   output logic                                 wr_en,
   output logic [scla_pkg::ADDR_W-1:0]          wr_addr,
   output logic [scla_pkg::CHAR_W-1:0]          wr_data,
   output logic                                 rd_en,
   output logic [scla_pkg::ADDR_W-1:0]          rd_addr,
   output scla_pkg::rd_tag_type                 rd_tag
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEND = 1'b1;

   logic                          state_ff,  state_in;
   logic [scla_pkg::FILL_W-1:0]   fill_ff,   fill_in;
   logic                          ready_ff,  ready_in;
   logic [scla_pkg::FILL_W-1:0]   rlen_ff,   rlen_in;
   logic [scla_pkg::ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   scla_pkg::rd_tag_type          rd_tag_ff, rd_tag_in;
   logic                          accept;
   logic                          is_last;
   logic [scla_pkg::CLS_W-1:0]    cls;

   assign req_stall = (state_ff == ST_SEND);
   assign accept    = req_valid && !req_stall;
   assign cls       = scla_pkg::classify(req_byte_value);
   assign is_last   = ((scla_pkg::FILL_W'(rd_idx_ff) + scla_pkg::FILL_W'(1)) == rlen_ff);

   // line editing and consume sequencing
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      ready_in  = ready_ff;
      rlen_in   = rlen_ff;
      rd_idx_in = rd_idx_ff;
      rd_tag_in = '0;
      wr_en     = 1'b0;
      wr_addr   = scla_pkg::ADDR_W'(fill_ff);
      wr_data   = req_byte_value[scla_pkg::CHAR_W-1:0];
      rd_en     = 1'b0;
      rd_addr   = rd_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  scla_pkg::MODE_BYTE: begin
                     if (!ready_ff) begin
                        case (cls)
                           scla_pkg::CLS_END: begin
                              if (fill_ff != '0) begin
                                 ready_in = 1'b1;
                                 rlen_in  = fill_ff;
                                 fill_in  = '0;
                              end
                           end
                           scla_pkg::CLS_ERASE: begin
                              if (fill_ff != '0) begin
                                 fill_in = fill_ff - scla_pkg::FILL_W'(1);
                              end
                           end
                           scla_pkg::CLS_APPEND: begin
                              if (fill_ff < scla_pkg::FILL_W'(scla_pkg::STORE_DEPTH)) begin
                                 wr_en   = 1'b1;
                                 fill_in = fill_ff + scla_pkg::FILL_W'(1);
                              end else begin
                                 fill_in = '0;
                              end
                           end
                           default: begin
                              fill_in = '0;
                           end
                        endcase
                     end
                  end
                  scla_pkg::MODE_LINK_ERR: begin
                     fill_in = '0;
                  end
                  scla_pkg::MODE_CONSUME: begin
                     if (ready_ff) begin
                        ready_in  = 1'b0;
                        rd_idx_in = '0;
                        state_in  = ST_SEND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEND: begin
            // one read in flight, issued only when the output register is free
            if (!rd_tag_ff.valid && out_free) begin
               rd_en           = 1'b1;
               rd_tag_in.valid = 1'b1;
               rd_tag_in.pos   = scla_pkg::POS_W'(rd_idx_ff);
               rd_tag_in.last  = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + scla_pkg::ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         ready_ff  <= 1'b0;
         rlen_ff   <= '0;
         rd_idx_ff <= '0;
         rd_tag_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         ready_ff  <= ready_in;
         rlen_ff   <= rlen_in;
         rd_idx_ff <= rd_idx_in;
         rd_tag_ff <= rd_tag_in;
      end
   end

   assign rd_tag = rd_tag_ff;

`ifndef SYNTHESIS
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= scla_pkg::FILL_W'(scla_pkg::STORE_DEPTH))
      else $error("partial line longer than store");

   a_no_write_while_ready: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!ready_ff && state_ff == ST_IDLE))
      else $error("store written while a line is held");

   a_send_clears_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (!ready_ff && rlen_ff != '0))
      else $error("sending without a captured line length");

   a_last_ends_send: assert property (@(posedge clock) disable iff (reset)
      (rd_tag_ff.valid && rd_tag_ff.last) |-> (state_ff == ST_IDLE))
      else $error("sequencer still busy after last read");
`endif

endmodule

// File: rtl/serial_command_line_assembler_top.sv
`timescale 1ns / 1ps
// a consume word sets the send state; each character then passes the store read and the output register
// throughput: one input word per cycle while no line is being sent
// each character takes one store read and one output load; a new read waits for the last one to clear
// req_stall stays high until the last store read is issued
// reset is synchronous and clears fill length, ready flag and output valid

module serial_command_line_assembler_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [scla_pkg::MODE_W-1:0]   req_mode,
   input  logic [scla_pkg::BYTE_W-1:0]   req_byte_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [scla_pkg::CHAR_W-1:0]   rsp_line_char,
   output logic [scla_pkg::POS_W-1:0]    rsp_char_position,
   output logic                          rsp_is_last
);

   logic                          wr_en;
   logic [scla_pkg::ADDR_W-1:0]   wr_addr;
   logic [scla_pkg::CHAR_W-1:0]   wr_data;
   logic                          rd_en;
   logic [scla_pkg::ADDR_W-1:0]   rd_addr;
   logic [scla_pkg::CHAR_W-1:0]   rd_data;
   scla_pkg::rd_tag_type          rd_tag;
   logic                          out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [scla_pkg::CHAR_W-1:0]   rsp_char_ff;
   logic [scla_pkg::POS_W-1:0]    rsp_pos_ff;
   logic                          rsp_last_ff;

   scla_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .out_free       (out_free),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_tag         (rd_tag)
   );

   scla_line_ram #(
      .DEPTH  (scla_pkg::STORE_DEPTH),
      .WIDTH  (scla_pkg::CHAR_W),
      .ADDR_W (scla_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register frees up when empty or taken at this edge
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rd_tag.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the word from the store read
   always_ff @(posedge clock) begin
      if (rd_tag.valid) begin
         rsp_char_ff <= rd_data;
         rsp_pos_ff  <= rd_tag.pos;
         rsp_last_ff <= rd_tag.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_char     = rsp_char_ff;
   assign rsp_char_position = rsp_pos_ff;
   assign rsp_is_last       = rsp_last_ff;

endmodule
